@@ hw/rtl/qrm_pkg.sv @@
`default_nettype none

package qrm_pkg;

    localparam int COMP_WIDTH = 16;
    localparam int FRAC_BITS  = 14;

    // Squared norm: four squares of COMP_WIDTH-bit components.
    localparam int PROD_W  = 2 * COMP_WIDTH;
    localparam int NORM_W  = PROD_W + 1;
    localparam int MAG_W   = PROD_W;
    // Magnitudes shifted along with the norm stay below twice the normalized norm.
    localparam int NMAG_W  = NORM_W;
    localparam int M_W     = 32;
    localparam int RECIP_W = 33;
    localparam int RECIP_LAT = RECIP_W;
    localparam int SHIFT_W = 6;

    localparam int NUM_ENT = 9;
    localparam int NUM_PROD = 10;

    localparam int LO_W    = 17;
    localparam int HI_W    = NMAG_W - LO_W;
    localparam int ACC_W   = NMAG_W + RECIP_W;
    localparam int RND_SH  = 63 - FRAC_BITS;
    localparam int T_W     = ACC_W - RND_SH;
    localparam int ENT_W   = FRAC_BITS + 3;

    // Product slots.
    localparam int P_XX = 0;
    localparam int P_YY = 1;
    localparam int P_ZZ = 2;
    localparam int P_WW = 3;
    localparam int P_XY = 4;
    localparam int P_XZ = 5;
    localparam int P_YZ = 6;
    localparam int P_WX = 7;
    localparam int P_WY = 8;
    localparam int P_WZ = 9;

    // Total register stages from accept to the result strobe.
    localparam int LATENCY = 4 + RECIP_LAT + 3;

    typedef struct packed {
        logic signed [COMP_WIDTH-1:0] qx;
        logic signed [COMP_WIDTH-1:0] qy;
        logic signed [COMP_WIDTH-1:0] qz;
        logic signed [COMP_WIDTH-1:0] qw;
    } qrm_in_t;

    typedef struct packed {
        logic signed [COMP_WIDTH-1:0] r0c0;
        logic signed [COMP_WIDTH-1:0] r1c0;
        logic signed [COMP_WIDTH-1:0] r2c0;
        logic signed [COMP_WIDTH-1:0] r0c1;
        logic signed [COMP_WIDTH-1:0] r1c1;
        logic signed [COMP_WIDTH-1:0] r2c1;
        logic signed [COMP_WIDTH-1:0] r0c2;
        logic signed [COMP_WIDTH-1:0] r1c2;
        logic signed [COMP_WIDTH-1:0] r2c2;
    } qrm_out_t;

endpackage

`default_nettype wire

@@ hw/rtl/qrm_recip.sv @@
`default_nettype none

// Pipelined restoring divider: recip = floor(2^63 / m), m in [2^31, 2^32).
// One quotient bit per stage, RECIP_LAT stages.
module qrm_recip (
    input  wire logic                       clk,
    input  wire logic [qrm_pkg::M_W-1:0]    m,
    output logic      [qrm_pkg::RECIP_W-1:0] recip
);
    import qrm_pkg::*;

    logic [M_W:0]       p_reg [RECIP_LAT];
    logic [M_W-1:0]     m_reg [RECIP_LAT];
    logic [RECIP_W-1:0] q_reg [RECIP_LAT];

    genvar s;
    generate
        for (s = 0; s < RECIP_LAT; s++)
        begin : g_step
            logic [M_W:0]       p_in;
            logic [M_W-1:0]     m_in;
            logic [RECIP_W-1:0] q_in;
            logic               ge;
            logic [M_W:0]       p_next;

            if (s == 0)
            begin : g_first
                // Top 32 bits of the dividend 2^63.
                assign p_in = (M_W + 1)'(1) << (M_W - 1);
                assign m_in = m;
                assign q_in = '0;
            end
            else
            begin : g_rest
                // Bring down a zero dividend bit.
                assign p_in = {p_reg[s-1][M_W-1:0], 1'b0};
                assign m_in = m_reg[s-1];
                assign q_in = q_reg[s-1];
            end

            always_comb
            begin
                ge     = p_in >= {1'b0, m_in};
                p_next = ge ? p_in - {1'b0, m_in} : p_in;
            end

            always_ff @(posedge clk)
            begin
                p_reg[s] <= p_next;
                m_reg[s] <= m_in;
                q_reg[s] <= {q_in[RECIP_W-2:0], ge};
            end
        end
    endgenerate

    assign recip = q_reg[RECIP_LAT-1];

endmodule

`default_nettype wire

@@ hw/rtl/quaternion_to_rotation_matrix.sv @@
`default_nettype none

// Quaternion to 3x3 rotation matrix.
// Input: quat carries one quaternion (qx, qy, qz, qw), signed, 14 fraction
// bits, not necessarily of unit length. A beat is taken at a rising edge with
// start high and busy low; busy stays low, so a beat may enter every cycle.
// Output: matrix carries the nine entries, signed, 14 fraction bits, each
// limited to plus or minus one. done marks a result for exactly one cycle and
// the beat is taken at the edge that ends it; the receiver cannot stall.
// Pipeline: results leave in the order their beats were taken; throughput is
// one beat per cycle. The depth is set by the reciprocal of the squared norm,
// a restoring divider with one quotient bit per stage (33 stages), plus
// products, sums, a two-stage normalizer, a split multiply, the rounding add
// and the output register.
// A zero-norm quaternion gives the identity matrix.
// Reset clears every valid bit; beats in flight are dropped and no result
// appears until new beats arrive.
module quaternion_to_rotation_matrix (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire qrm_pkg::qrm_in_t  quat,
    output logic                   done,
    output qrm_pkg::qrm_out_t      matrix
);
    import qrm_pkg::*;

    assign busy = 1'b0;

    // Stage 1: component products.
    logic                     s1_valid_reg;
    logic signed [PROD_W-1:0] s1_prod_reg [NUM_PROD];

    function automatic logic signed [PROD_W-1:0] wide(input logic signed [COMP_WIDTH-1:0] v);
        wide = PROD_W'(v);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_prod_reg[P_XX] <= wide(quat.qx) * wide(quat.qx);
        s1_prod_reg[P_YY] <= wide(quat.qy) * wide(quat.qy);
        s1_prod_reg[P_ZZ] <= wide(quat.qz) * wide(quat.qz);
        s1_prod_reg[P_WW] <= wide(quat.qw) * wide(quat.qw);
        s1_prod_reg[P_XY] <= wide(quat.qx) * wide(quat.qy);
        s1_prod_reg[P_XZ] <= wide(quat.qx) * wide(quat.qz);
        s1_prod_reg[P_YZ] <= wide(quat.qy) * wide(quat.qz);
        s1_prod_reg[P_WX] <= wide(quat.qw) * wide(quat.qx);
        s1_prod_reg[P_WY] <= wide(quat.qw) * wide(quat.qy);
        s1_prod_reg[P_WZ] <= wide(quat.qw) * wide(quat.qz);
    end

    // Stage 2: norm, diagonal sums, off-diagonal sums as sign and magnitude.
    logic               s2_valid_reg;
    logic [NORM_W-1:0]  s2_norm_reg;
    logic [MAG_W-1:0]   s2_mag_reg [NUM_ENT];
    logic               s2_neg_reg [NUM_ENT];

    logic [NORM_W-1:0]  norm_next;
    logic [MAG_W-1:0]   mag_next [NUM_ENT];
    logic               neg_next [NUM_ENT];
    logic signed [NORM_W-1:0] off_sum [NUM_ENT];

    function automatic logic signed [NORM_W-1:0] sx(input logic signed [PROD_W-1:0] v);
        sx = NORM_W'(v);
    endfunction

    always_comb
    begin
        norm_next = NORM_W'(s1_prod_reg[P_XX]) + NORM_W'(s1_prod_reg[P_YY])
                  + NORM_W'(s1_prod_reg[P_ZZ]) + NORM_W'(s1_prod_reg[P_WW]);
        off_sum[0] = '0;
        off_sum[4] = '0;
        off_sum[8] = '0;
        off_sum[1] = sx(s1_prod_reg[P_XY]) + sx(s1_prod_reg[P_WZ]);
        off_sum[2] = sx(s1_prod_reg[P_XZ]) - sx(s1_prod_reg[P_WY]);
        off_sum[3] = sx(s1_prod_reg[P_XY]) - sx(s1_prod_reg[P_WZ]);
        off_sum[5] = sx(s1_prod_reg[P_YZ]) + sx(s1_prod_reg[P_WX]);
        off_sum[6] = sx(s1_prod_reg[P_XZ]) + sx(s1_prod_reg[P_WY]);
        off_sum[7] = sx(s1_prod_reg[P_YZ]) - sx(s1_prod_reg[P_WX]);
        for (int e = 0; e < NUM_ENT; e++)
        begin
            neg_next[e] = off_sum[e][NORM_W-1];
            mag_next[e] = MAG_W'(neg_next[e] ? -off_sum[e] : off_sum[e]);
        end
        mag_next[0] = MAG_W'(s1_prod_reg[P_YY]) + MAG_W'(s1_prod_reg[P_ZZ]);
        mag_next[4] = MAG_W'(s1_prod_reg[P_XX]) + MAG_W'(s1_prod_reg[P_ZZ]);
        mag_next[8] = MAG_W'(s1_prod_reg[P_XX]) + MAG_W'(s1_prod_reg[P_YY]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_norm_reg <= norm_next;
        for (int e = 0; e < NUM_ENT; e++)
        begin
            s2_mag_reg[e] <= mag_next[e];
            s2_neg_reg[e] <= neg_next[e];
        end
    end

    // Stages 3 and 4: shift the norm left until its top bit is set, and
    // every magnitude by the same amount.
    logic               s3_valid_reg;
    logic               s3_zero_reg;
    logic [NORM_W-1:0]  s3_norm_reg;
    logic [NMAG_W-1:0]  s3_mag_reg [NUM_ENT];
    logic               s3_neg_reg [NUM_ENT];

    logic [SHIFT_W-1:0] sha;
    logic [NORM_W-1:0]  na32;
    logic [NORM_W-1:0]  na16;
    logic [NORM_W-1:0]  na8;

    always_comb
    begin
        na32 = (s2_norm_reg[NORM_W-1:1] == '0) ? s2_norm_reg << 32 : s2_norm_reg;
        na16 = (na32[NORM_W-1:NORM_W-16] == '0) ? na32 << 16 : na32;
        na8  = (na16[NORM_W-1:NORM_W-8] == '0) ? na16 << 8 : na16;
        sha  = {(s2_norm_reg[NORM_W-1:1] == '0), (na32[NORM_W-1:NORM_W-16] == '0),
                (na16[NORM_W-1:NORM_W-8] == '0), 3'b000};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_zero_reg <= (s2_norm_reg == '0);
        s3_norm_reg <= na8;
        for (int e = 0; e < NUM_ENT; e++)
        begin
            s3_mag_reg[e] <= NMAG_W'(s2_mag_reg[e]) << sha;
            s3_neg_reg[e] <= s2_neg_reg[e];
        end
    end

    logic               s4_valid_reg;
    logic               s4_zero_reg;
    logic [M_W-1:0]     s4_m_reg;
    logic [NMAG_W-1:0]  s4_mag_reg [NUM_ENT];
    logic               s4_neg_reg [NUM_ENT];

    logic [SHIFT_W-1:0] shb;
    logic [NORM_W-1:0]  nb4;
    logic [NORM_W-1:0]  nb2;
    logic [NORM_W-1:0]  nb1;

    always_comb
    begin
        nb4 = (s3_norm_reg[NORM_W-1:NORM_W-4] == '0) ? s3_norm_reg << 4 : s3_norm_reg;
        nb2 = (nb4[NORM_W-1:NORM_W-2] == '0) ? nb4 << 2 : nb4;
        nb1 = (nb2[NORM_W-1] == 1'b0) ? nb2 << 1 : nb2;
        shb = {3'b000, (s3_norm_reg[NORM_W-1:NORM_W-4] == '0),
               (nb4[NORM_W-1:NORM_W-2] == '0), (nb2[NORM_W-1] == 1'b0)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_zero_reg <= s3_zero_reg;
        // Drop the lowest bit: m = norm * 2^k with m in [2^31, 2^32).
        s4_m_reg    <= nb1[NORM_W-1:1];
        for (int e = 0; e < NUM_ENT; e++)
        begin
            s4_mag_reg[e] <= s3_mag_reg[e] << shb;
            s4_neg_reg[e] <= s3_neg_reg[e];
        end
    end

    // Reciprocal, with the payload held in a matching delay line.
    logic [RECIP_W-1:0] recip;

    qrm_recip u_recip (
        .clk   (clk),
        .m     (s4_m_reg),
        .recip (recip)
    );

    logic               dl_valid_reg [RECIP_LAT];
    logic               dl_zero_reg  [RECIP_LAT];
    logic [NMAG_W-1:0]  dl_mag_reg   [RECIP_LAT][NUM_ENT];
    logic               dl_neg_reg   [RECIP_LAT][NUM_ENT];

    genvar d;
    generate
        for (d = 0; d < RECIP_LAT; d++)
        begin : g_dly
            if (d == 0)
            begin : g_head
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        dl_valid_reg[d] <= 1'b0;
                    end
                    else
                    begin
                        dl_valid_reg[d] <= s4_valid_reg;
                    end
                end

                always_ff @(posedge clk)
                begin
                    dl_zero_reg[d] <= s4_zero_reg;
                    dl_mag_reg[d]  <= s4_mag_reg;
                    dl_neg_reg[d]  <= s4_neg_reg;
                end
            end
            else
            begin : g_tap
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        dl_valid_reg[d] <= 1'b0;
                    end
                    else
                    begin
                        dl_valid_reg[d] <= dl_valid_reg[d-1];
                    end
                end

                always_ff @(posedge clk)
                begin
                    dl_zero_reg[d] <= dl_zero_reg[d-1];
                    dl_mag_reg[d]  <= dl_mag_reg[d-1];
                    dl_neg_reg[d]  <= dl_neg_reg[d-1];
                end
            end
        end
    endgenerate

    // Multiply stage: split the magnitude into two partial products.
    logic                          mu_valid_reg;
    logic                          mu_zero_reg;
    logic [LO_W+RECIP_W-1:0]       mu_lo_reg [NUM_ENT];
    logic [HI_W+RECIP_W-1:0]       mu_hi_reg [NUM_ENT];
    logic                          mu_neg_reg [NUM_ENT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_valid_reg <= 1'b0;
        end
        else
        begin
            mu_valid_reg <= dl_valid_reg[RECIP_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        mu_zero_reg <= dl_zero_reg[RECIP_LAT-1];
        for (int e = 0; e < NUM_ENT; e++)
        begin
            mu_lo_reg[e]  <= (LO_W+RECIP_W)'(dl_mag_reg[RECIP_LAT-1][e][LO_W-1:0])
                           * (LO_W+RECIP_W)'(recip);
            mu_hi_reg[e]  <= (HI_W+RECIP_W)'(dl_mag_reg[RECIP_LAT-1][e][NMAG_W-1:LO_W])
                           * (HI_W+RECIP_W)'(recip);
            mu_neg_reg[e] <= dl_neg_reg[RECIP_LAT-1][e];
        end
    end

    // Accumulate stage: join partial products, round half up, fixed shift.
    logic              ac_valid_reg;
    logic              ac_zero_reg;
    logic [T_W-1:0]    ac_t_reg [NUM_ENT];
    logic              ac_neg_reg [NUM_ENT];
    logic [ACC_W-1:0]  acc_sum [NUM_ENT];

    always_comb
    begin
        for (int e = 0; e < NUM_ENT; e++)
        begin
            acc_sum[e] = ACC_W'(mu_lo_reg[e]) + (ACC_W'(mu_hi_reg[e]) << LO_W)
                       + (ACC_W'(1) << (RND_SH - 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac_valid_reg <= 1'b0;
        end
        else
        begin
            ac_valid_reg <= mu_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ac_zero_reg <= mu_zero_reg;
        for (int e = 0; e < NUM_ENT; e++)
        begin
            ac_t_reg[e]   <= acc_sum[e][ACC_W-1:RND_SH];
            ac_neg_reg[e] <= mu_neg_reg[e];
        end
    end

    // Output stage: limit, restore sign, form diagonal, identity on zero norm.
    localparam logic [T_W-1:0] ONE_T = T_W'(1) << FRAC_BITS;
    localparam logic [T_W-1:0] TWO_T = T_W'(2) << FRAC_BITS;

    logic                  done_reg;
    logic [COMP_WIDTH-1:0] ent_next [NUM_ENT];
    logic [COMP_WIDTH-1:0] ent_reg  [NUM_ENT];
    logic [ENT_W-1:0]      lim      [NUM_ENT];
    logic [ENT_W-1:0]      val      [NUM_ENT];

    always_comb
    begin
        for (int e = 0; e < NUM_ENT; e++)
        begin
            if ((e % 4) == 0)
            begin
                lim[e] = ENT_W'((ac_t_reg[e] > TWO_T) ? TWO_T : ac_t_reg[e]);
                val[e] = ENT_W'(ONE_T) - lim[e];
                if (ac_zero_reg)
                begin
                    val[e] = ENT_W'(ONE_T);
                end
            end
            else
            begin
                lim[e] = ENT_W'((ac_t_reg[e] > ONE_T) ? ONE_T : ac_t_reg[e]);
                val[e] = ac_neg_reg[e] ? -lim[e] : lim[e];
                if (ac_zero_reg)
                begin
                    val[e] = '0;
                end
            end
            ent_next[e] = val[e][COMP_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ac_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign done        = done_reg;
    assign matrix.r0c0 = ent_reg[0];
    assign matrix.r1c0 = ent_reg[1];
    assign matrix.r2c0 = ent_reg[2];
    assign matrix.r0c1 = ent_reg[3];
    assign matrix.r1c1 = ent_reg[4];
    assign matrix.r2c1 = ent_reg[5];
    assign matrix.r0c2 = ent_reg[6];
    assign matrix.r1c2 = ent_reg[7];
    assign matrix.r2c2 = ent_reg[8];

    localparam logic signed [COMP_WIDTH-1:0] POS_ONE = COMP_WIDTH'(1) << FRAC_BITS;
    localparam logic signed [COMP_WIDTH-1:0] NEG_ONE = -POS_ONE;

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result strobe missing after accepted beat");

    a_diag_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($signed(matrix.r0c0) <= POS_ONE && $signed(matrix.r0c0) >= NEG_ONE
               && $signed(matrix.r1c1) <= POS_ONE && $signed(matrix.r1c1) >= NEG_ONE
               && $signed(matrix.r2c2) <= POS_ONE && $signed(matrix.r2c2) >= NEG_ONE))
        else $error("diagonal entry beyond one");

    a_zero_identity: assert property (@(posedge clk) disable iff (!rst_n)
        (ac_valid_reg && ac_zero_reg) |=> (done && matrix.r1c1 == POS_ONE
                                           && matrix.r1c0 == '0))
        else $error("zero norm did not give identity");

endmodule

`default_nettype wire

@@ dv/tb_quaternion_to_rotation_matrix.sv @@
`timescale 1ns / 1ps

module tb_quaternion_to_rotation_matrix;
    import qrm_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    qrm_in_t  quat;
    logic     done;
    qrm_out_t matrix;

    qrm_in_t  pending_quats[$];
    qrm_out_t expected_matrices[$];
    int       gap_left;
    int       n_sent;
    int       n_checked;
    int       n_mismatch;
    int       n_unexpected;
    bit       stim_done;

    quaternion_to_rotation_matrix u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .quat(quat), .done(done), .matrix(matrix)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Rounded value of mag * recip shifted right by sh, limited to lim.
    function automatic longint unsigned scaled_mag(longint unsigned mag,
            longint unsigned recip, int sh, longint unsigned lim);
        longint unsigned t;
        t = (mag * recip + (64'd1 << (sh - 1))) >> sh;
        return (t > lim) ? lim : t;
    endfunction

    function automatic logic signed [COMP_WIDTH-1:0] off_term(longint unsigned p,
            longint unsigned recip, int sh);
        bit neg;
        longint unsigned mag;
        longint t;
        neg = p[63];
        mag = neg ? 64'd0 - p : p;
        t = longint'(scaled_mag(mag, recip, sh, 64'd1 << FRAC_BITS));
        return COMP_WIDTH'(neg ? -t : t);
    endfunction

    function automatic logic signed [COMP_WIDTH-1:0] diag_term(longint unsigned q,
            longint unsigned recip, int sh);
        longint one;
        one = longint'(1) << FRAC_BITS;
        return COMP_WIDTH'(one - longint'(scaled_mag(q, recip, sh, 64'd2 << FRAC_BITS)));
    endfunction

    function automatic qrm_out_t rotation_of(qrm_in_t q);
        longint x, y, z, w;
        longint unsigned xx, yy, zz, ww, xy, xz, yz, wx, wy, wz, nrm, m, recip;
        int k, sh;
        qrm_out_t r;
        x = longint'(q.qx); y = longint'(q.qy); z = longint'(q.qz); w = longint'(q.qw);
        xx = x * x; yy = y * y; zz = z * z; ww = w * w;
        xy = x * y; xz = x * z; yz = y * z;
        wx = w * x; wy = w * y; wz = w * z;
        nrm = xx + yy + zz + ww;
        r = '0;
        if (nrm == 0)
        begin
            r.r0c0 = COMP_WIDTH'(1) << FRAC_BITS;
            r.r1c1 = COMP_WIDTH'(1) << FRAC_BITS;
            r.r2c2 = COMP_WIDTH'(1) << FRAC_BITS;
            return r;
        end
        m = nrm;
        k = 0;
        while (m < (64'd1 << 31))
        begin
            m = m << 1;
            k++;
        end
        while (m >= (64'd1 << 32))
        begin
            m = m >> 1;
            k--;
        end
        recip = (64'd1 << 63) / m;
        sh = 62 - k - FRAC_BITS;
        if (sh < 1) sh = 1;
        if (sh > 63) sh = 63;
        r.r0c0 = diag_term(yy + zz, recip, sh);
        r.r1c0 = off_term(xy + wz, recip, sh);
        r.r2c0 = off_term(xz - wy, recip, sh);
        r.r0c1 = off_term(xy - wz, recip, sh);
        r.r1c1 = diag_term(xx + zz, recip, sh);
        r.r2c1 = off_term(yz + wx, recip, sh);
        r.r0c2 = off_term(xz + wy, recip, sh);
        r.r1c2 = off_term(yz - wx, recip, sh);
        r.r2c2 = diag_term(xx + yy, recip, sh);
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [15:0] rand_comp();
        int roll;
        roll = $urandom_range(0, 9);
        case (roll)
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 7) - 3);
            3, 4: return 16'($urandom_range(0, 32767) - 16384);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic qrm_in_t mk(int x, int y, int z, int w);
        qrm_in_t q;
        q.qx = COMP_WIDTH'(x); q.qy = COMP_WIDTH'(y);
        q.qz = COMP_WIDTH'(z); q.qw = COMP_WIDTH'(w);
        return q;
    endfunction

    initial
    begin
        qrm_in_t q;
        int i;
        rst_n = 1'b0;
        start = 1'b0;
        quat = '0;
        gap_left = 0;
        n_sent = 0;
        n_checked = 0;
        n_mismatch = 0;
        n_unexpected = 0;
        stim_done = 1'b0;
        // zero norm, unit axes, tiny norm, extremes, ties and overshoot cases
        pending_quats.push_back(mk(0, 0, 0, 0));
        pending_quats.push_back(mk(0, 0, 0, 16384));
        pending_quats.push_back(mk(16384, 0, 0, 0));
        pending_quats.push_back(mk(0, 16384, 0, 0));
        pending_quats.push_back(mk(0, 0, 16384, 0));
        pending_quats.push_back(mk(11585, 0, 0, 11585));
        pending_quats.push_back(mk(8192, 8192, 8192, 8192));
        pending_quats.push_back(mk(-8192, 8192, -8192, 8192));
        pending_quats.push_back(mk(1, 0, 0, 0));
        pending_quats.push_back(mk(0, 0, 0, -1));
        pending_quats.push_back(mk(1, 1, 1, 1));
        pending_quats.push_back(mk(-1, 1, -1, 1));
        pending_quats.push_back(mk(-32768, -32768, -32768, -32768));
        pending_quats.push_back(mk(32767, 32767, 32767, 32767));
        pending_quats.push_back(mk(-32768, 0, 0, 0));
        pending_quats.push_back(mk(32767, -32768, 32767, -32768));
        pending_quats.push_back(mk(0, 0, 0, 32767));
        pending_quats.push_back(mk(3, 5, 7, 11));
        pending_quats.push_back(mk(1, 2, 0, 0));
        pending_quats.push_back(mk(-32768, 1, 0, 0));
        for (i = 0; i < 1500; i++)
        begin
            q.qx = rand_comp();
            q.qy = rand_comp();
            q.qz = rand_comp();
            q.qw = rand_comp();
            pending_quats.push_back(q);
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Driver: hold start high across back-to-back beats, drop it in gaps and once the stimulus runs out.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_matrices.push_back(rotation_of(quat));
                n_sent++;
            end
            if (start && busy)
            begin
                // hold the current beat
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_quats.size() > 0)
            begin
                quat <= pending_quats.pop_front();
                start <= 1'b1;
                gap_left = pick_gap();
            end
            else
            begin
                start <= 1'b0;
                stim_done = 1'b1;
            end
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        qrm_out_t exp_m;
        if (rst_n && done)
        begin
            if (expected_matrices.size() == 0)
            begin
                n_unexpected++;
                $display("unexpected result beat: %h", matrix);
            end
            else
            begin
                exp_m = expected_matrices.pop_front();
                n_checked++;
                if (matrix !== exp_m)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch on beat %0d: expected %h got %h",
                                 n_checked, exp_m, matrix);
                end
            end
        end
    end

    initial
    begin
        wait (stim_done);
        wait (expected_matrices.size() == 0);
        repeat (LATENCY + 20) @(posedge clk);
        $display("Sent %0d quaternions incl. zero norm, axes and extremes; checked %0d",
                 n_sent, n_checked);
        if (n_mismatch == 0 && n_unexpected == 0 && expected_matrices.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("FAILURE");
        $finish;
    end

endmodule
